// ===== hdl/weighted_round_robin_selector_assert.svh =====
// Assertion macros shared by the weighted round-robin selector RTL.
`ifndef WEIGHTED_ROUND_ROBIN_SELECTOR_ASSERT_SVH
`define WEIGHTED_ROUND_ROBIN_SELECTOR_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define WRR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define WRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/wrr_pkg.sv =====
// Types, codes and default sizes shared by the weighted round-robin selector.
package wrr_pkg;

    // Default table size and stored weight width.
    localparam int NUM_SLOTS_DEF    = 16;
    localparam int WEIGHT_WIDTH_DEF = 16;

    // Fixed widths of the request and result fields.
    localparam int SLOT_IDX_W = 4;
    localparam int FIELD_WT_W = 16;

    // Request kinds.
    typedef enum logic {
        REQ_ADVANCE = 1'b0,
        REQ_UPDATE  = 1'b1
    } req_type_t;

    // One request as presented on the input port.
    typedef struct packed {
        req_type_t               req_type;
        logic [SLOT_IDX_W-1:0]   slot_index;
        logic                    slot_present;
        logic                    slot_started;
        logic [FIELD_WT_W-1:0]   slot_weight;
    } req_t;

    // One result as presented on the output port.
    typedef struct packed {
        logic [SLOT_IDX_W-1:0]   selected_slot;
        logic                    at_local;
        logic                    table_empty;
    } rsp_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic adv;   // latch the starting position of an advance
        logic upd;   // apply an update request
        logic load;  // resolve the end position and fetch the slot weight
        logic step;  // one search iteration
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;       // no slot is present
        logic step_fin;    // the current iteration ends the search
        logic step_to_end; // the current iteration lands on the end position
    } dp_status_t;

endpackage

// ===== hdl/wrr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wrr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/wrr_ctrl.sv =====
// Sequencing state machine of the weighted round-robin selector.
module wrr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  wrr_pkg::req_type_t    req_type,
    input  wrr_pkg::dp_status_t   status,
    output wrr_pkg::dp_cmd_t      cmd,
    output logic                  busy,
    output logic                  done
);

    import wrr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_UPDATE)
                    begin
                        cmd.upd    = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.adv    = 1'b1;
                        state_next = status.empty ? ST_DONE : ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                if (status.step_fin)
                begin
                    state_next = ST_DONE;
                end
                else if (status.step_to_end)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

// ===== hdl/wrr_datapath.sv =====
// Slot table, position and repeat counter of the weighted round-robin selector.
module wrr_datapath #(
    parameter int NUM_SLOTS    = wrr_pkg::NUM_SLOTS_DEF,
    parameter int WEIGHT_WIDTH = wrr_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wrr_pkg::req_t         req,
    input  wrr_pkg::dp_cmd_t      cmd,
    output wrr_pkg::dp_status_t   status,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    output wrr_pkg::rsp_t         rsp
);

    import wrr_pkg::*;

    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    // A search that never finds a target is cut off after this many steps.
    localparam int GUARD_STEPS = 4 * NUM_SLOTS + 4;
    localparam int GUARD_W     = $clog2(GUARD_STEPS);

    // Slot flags and control registers.
    logic [NUM_SLOTS-1:0]    present_reg;
    logic [NUM_SLOTS-1:0]    started_reg;
    logic                    pos_end_reg;
    logic [SLOT_W-1:0]       pos_slot_reg;
    logic                    old_end_reg;
    logic [SLOT_W-1:0]       old_slot_reg;
    logic [WEIGHT_WIDTH-1:0] rc_reg;
    logic                    force_reg;
    logic                    include_local_reg;
    logic [GUARD_W-1:0]      step_cnt_reg;
    logic                    spend_reg;

    // Search results and step values.
    logic                    first_found;
    logic [SLOT_W-1:0]       first_idx;
    logic [SLOT_W-1:0]       base_slot;
    logic                    next_found;
    logic [SLOT_W-1:0]       next_idx;
    logic [WEIGHT_WIDTH-1:0] weight;
    logic                    stay;
    logic                    np_end;
    logic [SLOT_W-1:0]       np_slot;
    logic [WEIGHT_WIDTH-1:0] rc_step;
    logic                    same_old;
    logic                    step_last;
    logic                    spend_next;
    logic [SLOT_W-1:0]       upd_slot;
    logic                    idx_ok;
    logic                    was_present;
    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_raddr;

    assign upd_slot    = SLOT_W'(req.slot_index);
    assign idx_ok      = (int'(req.slot_index) < NUM_SLOTS);
    assign was_present = present_reg[upd_slot];

    // Lowest present slot.
    always_comb
    begin
        first_found = |present_reg;
        first_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (present_reg[i])
            begin
                first_idx = SLOT_W'(i);
            end
        end
    end

    // Lowest present slot above the base: the current slot, or the updated one.
    assign base_slot = cmd.upd ? upd_slot : pos_slot_reg;

    always_comb
    begin
        next_found = 1'b0;
        next_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (present_reg[i] && (i > int'(base_slot)))
            begin
                next_found = 1'b1;
                next_idx   = SLOT_W'(i);
            end
        end
    end

    // Weights live in a RAM. Only the weights of present slots are used, and a
    // slot becomes present through an update that also writes its weight. During
    // a search step the slot being moved to is fetched, so the weight always
    // follows the position.
    assign ram_we    = cmd.upd && idx_ok;
    assign ram_raddr = cmd.step ? np_slot : (pos_end_reg ? first_idx : pos_slot_reg);

    wrr_ram #(
        .WIDTH (WEIGHT_WIDTH),
        .DEPTH (NUM_SLOTS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (upd_slot),
        .wdata (WEIGHT_WIDTH'(req.slot_weight)),
        .raddr (ram_raddr),
        .rdata (weight)
    );

    // One search iteration. After landing on an unstarted slot the next
    // iteration always moves on, so no weight is needed for that move.
    always_comb
    begin
        stay = !force_reg && (rc_reg < weight);
        if (stay)
        begin
            np_end  = 1'b0;
            np_slot = pos_slot_reg;
            rc_step = rc_reg + 1'b1;
        end
        else
        begin
            np_end  = !next_found;
            np_slot = next_idx;
            rc_step = '0;
        end
        same_old = (np_end && old_end_reg) ||
                   (!np_end && !old_end_reg && (np_slot == old_slot_reg));
    end

    // The last allowed step ends the search. If it stops on an unstarted slot
    // other than the start, that slot's picks count as used up.
    assign step_last  = (step_cnt_reg == GUARD_W'(GUARD_STEPS - 1));
    assign spend_next = cmd.step && step_last && !np_end && !started_reg[np_slot] &&
                        !same_old;

    assign status.empty       = !first_found;
    assign status.step_to_end = np_end;
    assign status.step_fin    = (include_local_reg && np_end) ||
                                (!np_end && started_reg[np_slot]) || same_old ||
                                step_last;

    // Register updates for each command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg       <= '0;
            started_reg       <= '0;
            pos_end_reg       <= 1'b1;
            pos_slot_reg      <= '0;
            old_end_reg       <= 1'b1;
            old_slot_reg      <= '0;
            rc_reg            <= '0;
            force_reg         <= 1'b0;
            include_local_reg <= 1'b0;
            step_cnt_reg      <= '0;
            spend_reg         <= 1'b0;
        end
        else
        begin
            spend_reg <= spend_next;
            if (cfg_wr_en)
            begin
                include_local_reg <= cfg_wr_data;
            end
            if (cmd.adv)
            begin
                old_end_reg  <= pos_end_reg;
                old_slot_reg <= pos_slot_reg;
                step_cnt_reg <= '0;
            end
            if (cmd.load)
            begin
                force_reg <= 1'b0;
                if (pos_end_reg)
                begin
                    pos_end_reg  <= 1'b0;
                    pos_slot_reg <= first_idx;
                end
            end
            if (cmd.step)
            begin
                pos_end_reg  <= np_end;
                pos_slot_reg <= np_slot;
                rc_reg       <= rc_step;
                force_reg    <= !np_end;
                step_cnt_reg <= step_cnt_reg + 1'b1;
            end
            // The weight of the slot where a cut-off search stopped is now read.
            if (spend_reg && (rc_reg < weight))
            begin
                rc_reg <= weight;
            end
            if (cmd.upd && idx_ok)
            begin
                // Removing the current slot moves the position to the next one.
                if (was_present && !req.slot_present && !pos_end_reg &&
                    (pos_slot_reg == upd_slot))
                begin
                    pos_end_reg  <= !next_found;
                    pos_slot_reg <= next_idx;
                    rc_reg       <= '0;
                end
                if (!was_present && req.slot_present && pos_end_reg)
                begin
                    rc_reg <= '0;
                end
                present_reg[upd_slot] <= req.slot_present;
                started_reg[upd_slot] <= req.slot_started;
            end
        end
    end

    // Result fields follow the registers.
    assign rsp.selected_slot = pos_end_reg ? '0 : SLOT_IDX_W'(pos_slot_reg);
    assign rsp.at_local      = pos_end_reg;
    assign rsp.table_empty   = !first_found;

endmodule

// ===== hdl/weighted_round_robin_selector.sv =====
// Top level of the weighted round-robin selector.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low. An update request writes one slot of the table (present flag, started
// flag, weight); an advance request moves the current position to the next
// target according to the weights. Every request gives exactly one result on
// rsp, shown for one cycle while done is high; the receiver has no way to stall
// it, so it must sample rsp whenever done is high.
// An update, or an advance on an empty table, shows done in the cycle after
// acceptance. An advance takes one weight fetch, then one search step after
// another, with one more fetch each time the search wraps through the end
// position. A search that finds no started target ends after at most
// 4 * NUM_SLOTS + 4 steps. A new request is not taken while busy is high, so
// each request gives its result before the next one is accepted.
// The include_local register is written with cfg_wr_en and cfg_wr_data; the
// user must write it only while the block is idle, as the block does not
// enforce this. Reset empties the table, places the position at the end
// position and clears include_local; no request is pending after reset.
module weighted_round_robin_selector #(
    parameter int NUM_SLOTS    = wrr_pkg::NUM_SLOTS_DEF,
    parameter int WEIGHT_WIDTH = wrr_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  wrr_pkg::req_t   req,
    output logic            done,
    output wrr_pkg::rsp_t   rsp,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data
);

    import wrr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Request sequencing.
    wrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    // Slot table and position state.
    wrr_datapath #(
        .NUM_SLOTS    (NUM_SLOTS),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rsp         (rsp)
    );

    // Checks on the sequencing.
`include "weighted_round_robin_selector_assert.svh"

    `WRR_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done,
                     "done held for more than one cycle")
    `WRR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy,
                     "accepted request did not set busy")
    `WRR_ASSERT_NEXT(a_fin_done, clk, rst_n, cmd.step && status.step_fin, done,
                     "finished search gave no result")
    `WRR_ASSERT_NEXT(a_empty_quick, clk, rst_n,
                     start && !busy && (req.req_type == REQ_ADVANCE) && rsp.table_empty,
                     done, "advance on empty table not answered at once")

endmodule
